// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define N2KFP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define N2KFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/n2kfp_pkg.sv =====
// shared types, constants and the fast-packet pgn lookup
// no dependencies
`timescale 1ns / 1ps

package n2kfp_pkg;

  localparam int NUM_SLOTS_DEF  = 8;
  localparam int SLOT_BYTES_DEF = 256;
  localparam int LANES          = 8;
  localparam int KEY_W          = 36;
  localparam int NUM_FAST       = 36;
  localparam logic [15:0] MAX_AGE_RST = 16'd100;
  localparam logic [7:0]  PF_PDU2     = 8'd240;
  localparam logic [4:0]  CNT_LAST    = 5'h1F;
  localparam logic [7:0]  START_BYTES = 8'd6;
  localparam logic [7:0]  NEXT_BYTES  = 8'd7;
  localparam logic [7:0]  RAW_LENGTH  = 8'd8;

  localparam logic [16:0] FAST_PGNS [NUM_FAST] = '{
    17'd65240,  17'd126208, 17'd126464, 17'd126996, 17'd126998, 17'd127233,
    17'd127237, 17'd127489, 17'd127496, 17'd127506, 17'd128275, 17'd129029,
    17'd129038, 17'd129039, 17'd129040, 17'd129041, 17'd129284, 17'd129285,
    17'd129540, 17'd129793, 17'd129794, 17'd129795, 17'd129797, 17'd129798,
    17'd129801, 17'd129802, 17'd129808, 17'd129809, 17'd129810, 17'd130065,
    17'd130074, 17'd130323, 17'd130577, 17'd130820, 17'd130822, 17'd130824
  };

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_DECIDE, ST_RAW, ST_EMIT_RD, ST_EMIT_LD
  } state_t;

  // per-slot record held in the slot table memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [7:0]       seq;
    logic [7:0]       len;
    logic [7:0]       cur;
    logic [31:0]      stamp;
  } meta_t;

  // one byte lane write
  typedef struct packed {
    logic       we;
    logic [7:0] data;
  } lane_wr_t;

  function automatic logic is_fast(input logic [16:0] p);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_FAST; i++) begin
      if (FAST_PGNS[i] == p) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== rtl/n2kfp_in_if.sv =====
// input channel: one received can frame with a time stamp
// no dependencies
`timescale 1ns / 1ps

interface n2kfp_in_if;
  logic        valid;
  logic        ready;
  logic [28:0] can_id;
  logic [63:0] frame_data;
  logic [31:0] now_seconds;

  modport source(output valid, can_id, frame_data, now_seconds, input ready);
  modport sink(input valid, can_id, frame_data, now_seconds, output ready);
endinterface

// ===== rtl/n2kfp_out_if.sv =====
// result channel: one 8-byte message chunk with its header fields
// no dependencies
`timescale 1ns / 1ps

interface n2kfp_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] pgn;
  logic [7:0]  source_addr;
  logic [7:0]  dest_addr;
  logic [2:0]  priority_res;
  logic [7:0]  msg_length;
  logic [4:0]  chunk_index;
  logic [63:0] chunk_data;
  logic        last_chunk;
  logic [15:0] dropped_count;

  modport source(output valid, pgn, source_addr, dest_addr, priority_res, msg_length,
                 chunk_index, chunk_data, last_chunk, dropped_count, input ready);
  modport sink(input valid, pgn, source_addr, dest_addr, priority_res, msg_length,
               chunk_index, chunk_data, last_chunk, dropped_count, output ready);
endinterface

// ===== rtl/n2kfp_meta_mem.sv =====
// slot table memory: one record per slot, registered read
// depends on n2kfp_pkg
`timescale 1ns / 1ps

module n2kfp_meta_mem #(
  parameter int NUM_SLOTS = n2kfp_pkg::NUM_SLOTS_DEF,
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              re,
  input  logic [SW-1:0]     raddr,
  output n2kfp_pkg::meta_t  rdata,
  input  logic              we,
  input  logic [SW-1:0]     waddr,
  input  n2kfp_pkg::meta_t  wdata
);

  n2kfp_pkg::meta_t mem [NUM_SLOTS];
  n2kfp_pkg::meta_t rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/n2kfp_byte_mem.sv =====
// message byte store: eight byte lanes, each with its own write address
// depends on n2kfp_pkg
`timescale 1ns / 1ps

module n2kfp_byte_mem #(
  parameter int NUM_SLOTS  = n2kfp_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_BYTES = n2kfp_pkg::SLOT_BYTES_DEF,
  localparam int WORDS = (SLOT_BYTES + 7) / 8,
  localparam int DEPTH = NUM_SLOTS * WORDS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  n2kfp_pkg::lane_wr_t  wr    [n2kfp_pkg::LANES],
  input  logic [AW-1:0]        waddr [n2kfp_pkg::LANES],
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [63:0]          rdata
);

  logic [7:0]  mem [n2kfp_pkg::LANES][DEPTH];
  logic [63:0] rdata_r;

  // per-lane write, all lanes read the same word
  always_ff @(posedge clk) begin
    for (int l = 0; l < n2kfp_pkg::LANES; l++) begin
      if (wr[l].we) mem[l][waddr[l]] <= wr[l].data;
      if (re) rdata_r[8*l +: 8] <= mem[l][raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/n2k_fast_packet_reassembler.sv =====
// top level: frame decode, slot scan sequencer and chunk emitter
// depends on n2kfp_pkg, n2kfp_in_if, n2kfp_out_if, n2kfp_meta_mem, n2kfp_byte_mem
//
//  channel   dir  handshake      content
//  in_ch     in   valid/ready    can_id, frame_data, now_seconds
//  out_ch    out  valid/ready    one 8-byte chunk plus header fields
//  cfg_*     in   write enable   max_age_seconds
//
// an item passes through the accept state, the scan state (one record read per
// cycle, every slot in turn), a check of the last record and the decide state;
// a raw frame adds a load state and a completed message a read and a load
// state per chunk, up to 32 chunks.
// reset is synchronous; it clears slot valid bits and the drop counter and
// restores the age limit, no memory clearing pass is needed.
// a stalled output holds the chunk and the emitter waits; a new item is taken
// as soon as the last chunk sits in the output register.
`timescale 1ns / 1ps

module n2k_fast_packet_reassembler #(
  parameter int NUM_SLOTS  = n2kfp_pkg::NUM_SLOTS_DEF,
  parameter int SLOT_BYTES = n2kfp_pkg::SLOT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  n2kfp_in_if.sink           in_ch,
  n2kfp_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WORDS = (SLOT_BYTES + 7) / 8;
  localparam int DEPTH = NUM_SLOTS * WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int L     = n2kfp_pkg::LANES;

  n2kfp_pkg::state_t state_r, state_nxt;

  logic [28:0] id_r, id_nxt;
  logic [63:0] data_r, data_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] max_age_r, max_age_nxt;
  logic [15:0] drop_r, drop_nxt;
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;

  logic [SW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [SW-1:0] chk_idx_r, chk_idx_nxt;

  logic          match_r, match_nxt;
  logic [SW-1:0] match_idx_r, match_idx_nxt;
  logic [7:0]    mseq_r, mseq_nxt;
  logic [7:0]    mlen_r, mlen_nxt;
  logic [7:0]    mcur_r, mcur_nxt;
  logic [31:0]   mtime_r, mtime_nxt;
  logic          free_r, free_nxt;
  logic [SW-1:0] free_idx_r, free_idx_nxt;

  logic [SW-1:0] emit_slot_r, emit_slot_nxt;
  logic [7:0]    emit_len_r, emit_len_nxt;
  logic [4:0]    emit_k_r, emit_k_nxt;
  logic [5:0]    emit_n_r, emit_n_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_len_r, out_len_nxt;
  logic [4:0]  out_idx_r, out_idx_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;
  logic [15:0] out_drop_r, out_drop_nxt;

  // frame decode from the held item
  logic [7:0]  src, ps, pf, dst;
  logic [16:0] pgn;
  logic [2:0]  prio;
  logic [7:0]  b [8];
  logic [n2kfp_pkg::KEY_W-1:0] key;
  logic        start, fast;

  always_comb begin
    src  = id_r[7:0];
    ps   = id_r[15:8];
    pf   = id_r[23:16];
    dst  = (pf < n2kfp_pkg::PF_PDU2) ? ps : 8'hFF;
    pgn  = {id_r[24], pf, (pf < n2kfp_pkg::PF_PDU2) ? 8'h00 : ps};
    prio = id_r[28:26];
    for (int i = 0; i < 8; i++) b[i] = data_r[8*i +: 8];
    key   = {pgn, src, dst, b[0][7:5]};
    start = (b[0][4:0] == 5'd0);
    fast  = n2kfp_pkg::is_fast(pgn);
  end

  // memories
  logic             meta_re, meta_we;
  logic [SW-1:0]    meta_raddr, meta_waddr;
  n2kfp_pkg::meta_t meta_rdata, meta_wdata;

  n2kfp_meta_mem #(.NUM_SLOTS(NUM_SLOTS)) u_meta (
    .clk   (clk),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata)
  );

  n2kfp_pkg::lane_wr_t bwr [L];
  logic [AW-1:0]       bwaddr [L];
  logic                bre;
  logic [AW-1:0]       braddr;
  logic [63:0]         brdata;

  n2kfp_byte_mem #(.NUM_SLOTS(NUM_SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_bytes (
    .clk   (clk),
    .wr    (bwr),
    .waddr (bwaddr),
    .re    (bre),
    .raddr (braddr),
    .rdata (brdata)
  );

  // decide-cycle conditions
  logic          is_next, do_open, do_drop, out_free;
  logic [SW-1:0] open_slot;
  logic [7:0]    new_cur;
  logic          emit_last;

  always_comb begin
    is_next   = match_r && (mseq_r[4:0] != n2kfp_pkg::CNT_LAST) && (b[0] == mseq_r + 8'd1);
    do_open   = !is_next && start && (match_r || free_r);
    do_drop   = match_r && !is_next && !start;
    open_slot = match_r ? match_idx_r : free_idx_r;
    new_cur   = mcur_r + n2kfp_pkg::NEXT_BYTES;
    out_free  = !out_valid_r || out_ch.ready;
    emit_last = (({1'b0, emit_k_r}) + 6'd1) == emit_n_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      n2kfp_pkg::ST_IDLE:      if (in_ch.valid) state_nxt = n2kfp_pkg::ST_SCAN;
      n2kfp_pkg::ST_SCAN:      if (scan_cnt_r == SW'(NUM_SLOTS - 1))
                                 state_nxt = n2kfp_pkg::ST_SCAN_LAST;
      n2kfp_pkg::ST_SCAN_LAST: state_nxt = n2kfp_pkg::ST_DECIDE;
      n2kfp_pkg::ST_DECIDE: begin
        if (!fast) state_nxt = n2kfp_pkg::ST_RAW;
        else if (is_next && (new_cur >= mlen_r)) state_nxt = n2kfp_pkg::ST_EMIT_RD;
        else if (do_open && (b[1] <= n2kfp_pkg::START_BYTES))
          state_nxt = n2kfp_pkg::ST_EMIT_RD;
        else state_nxt = n2kfp_pkg::ST_IDLE;
      end
      n2kfp_pkg::ST_RAW:       if (out_free) state_nxt = n2kfp_pkg::ST_IDLE;
      n2kfp_pkg::ST_EMIT_RD:   state_nxt = n2kfp_pkg::ST_EMIT_LD;
      n2kfp_pkg::ST_EMIT_LD: begin
        if (out_free) state_nxt = emit_last ? n2kfp_pkg::ST_IDLE : n2kfp_pkg::ST_EMIT_RD;
      end
      default:                 state_nxt = n2kfp_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  logic [7:0] p0, elen;
  logic [2:0] src_off, j;
  logic [3:0] cnt;
  logic [8:0] pos, n9;
  logic [7:0] cpos;
  logic       aged, eff;
  logic       load;

  always_comb begin
    id_nxt        = id_r;
    data_nxt      = data_r;
    now_nxt       = now_r;
    max_age_nxt   = cfg_we ? cfg_wdata : max_age_r;
    drop_nxt      = drop_r;
    valid_nxt     = valid_r;
    scan_cnt_nxt  = scan_cnt_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    mseq_nxt      = mseq_r;
    mlen_nxt      = mlen_r;
    mcur_nxt      = mcur_r;
    mtime_nxt     = mtime_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    emit_slot_nxt = emit_slot_r;
    emit_len_nxt  = emit_len_r;
    emit_k_nxt    = emit_k_r;
    emit_n_nxt    = emit_n_r;
    out_len_nxt   = out_len_r;
    out_idx_nxt   = out_idx_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    meta_re       = 1'b0;
    meta_raddr    = scan_cnt_r;
    meta_we       = 1'b0;
    meta_waddr    = open_slot;
    meta_wdata    = '0;
    bre           = 1'b0;
    braddr        = AW'(emit_slot_r) * AW'(WORDS) + AW'(emit_k_r);
    load          = 1'b0;
    aged          = 1'b0;
    eff           = 1'b0;
    p0            = 8'd0;
    src_off       = 3'd2;
    cnt           = 4'd6;
    elen          = b[1];
    n9            = 9'd0;
    cpos          = 8'd0;

    // record returned by the scan: ageing, key match, free slot
    if (chk_vld_r) begin
      aged = valid_r[chk_idx_r] &&
             ((now_r - meta_rdata.stamp) > {16'd0, max_age_r});
      eff  = valid_r[chk_idx_r] && !aged;
      if (aged) valid_nxt[chk_idx_r] = 1'b0;
      if (eff && (meta_rdata.key == key) && !match_r) begin
        match_nxt     = 1'b1;
        match_idx_nxt = chk_idx_r;
        mseq_nxt      = meta_rdata.seq;
        mlen_nxt      = meta_rdata.len;
        mcur_nxt      = meta_rdata.cur;
        mtime_nxt     = meta_rdata.stamp;
      end
      if (!eff && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
    end

    case (state_r)
      n2kfp_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          id_nxt       = in_ch.can_id;
          data_nxt     = in_ch.frame_data;
          now_nxt      = in_ch.now_seconds;
          match_nxt    = 1'b0;
          free_nxt     = 1'b0;
          scan_cnt_nxt = '0;
        end
      end
      n2kfp_pkg::ST_SCAN: begin
        meta_re      = 1'b1;
        chk_vld_nxt  = 1'b1;
        chk_idx_nxt  = scan_cnt_r;
        scan_cnt_nxt = scan_cnt_r + SW'(1);
      end
      n2kfp_pkg::ST_DECIDE: begin
        if (fast && is_next) begin
          meta_we    = 1'b1;
          meta_waddr = match_idx_r;
          meta_wdata = '{key: key, seq: b[0], len: mlen_r, cur: new_cur, stamp: mtime_r};
          if (new_cur >= mlen_r) valid_nxt[match_idx_r] = 1'b0;
          p0            = mcur_r;
          src_off       = 3'd1;
          cnt           = 4'd7;
          elen          = mlen_r;
          emit_slot_nxt = match_idx_r;
        end else if (fast && do_open) begin
          meta_we    = 1'b1;
          meta_waddr = open_slot;
          meta_wdata = '{key: key, seq: b[0], len: b[1], cur: n2kfp_pkg::START_BYTES,
                         stamp: now_r};
          valid_nxt[open_slot] = (b[1] > n2kfp_pkg::START_BYTES);
          emit_slot_nxt = open_slot;
        end else if (fast && do_drop) begin
          valid_nxt[match_idx_r] = 1'b0;
          if (drop_r != 16'hFFFF) drop_nxt = drop_r + 16'd1;
        end
        n9           = ({1'b0, elen} + 9'd7) >> 3;
        emit_len_nxt = elen;
        emit_k_nxt   = 5'd0;
        emit_n_nxt   = (elen == 8'd0) ? 6'd1 : n9[5:0];
      end
      n2kfp_pkg::ST_RAW: begin
        if (out_free) begin
          load         = 1'b1;
          out_len_nxt  = n2kfp_pkg::RAW_LENGTH;
          out_idx_nxt  = 5'd0;
          out_data_nxt = data_r;
          out_last_nxt = 1'b1;
          out_drop_nxt = drop_r;
        end
      end
      n2kfp_pkg::ST_EMIT_RD: bre = 1'b1;
      n2kfp_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          load         = 1'b1;
          out_len_nxt  = emit_len_r;
          out_idx_nxt  = emit_k_r;
          out_last_nxt = emit_last;
          out_drop_nxt = drop_r;
          for (int l = 0; l < L; l++) begin
            cpos = {emit_k_r, 3'(l)};
            out_data_nxt[8*l +: 8] = (cpos < emit_len_r) ? brdata[8*l +: 8] : 8'd0;
          end
          emit_k_nxt = emit_k_r + 5'd1;
        end
      end
      default: ;
    endcase

    // byte lane writes for a start or next frame
    for (int l = 0; l < L; l++) begin
      j          = 3'(l) - p0[2:0];
      pos        = {1'b0, p0} + {6'd0, j};
      bwr[l].we  = (state_r == n2kfp_pkg::ST_DECIDE) && fast && (is_next || do_open) &&
                   ({1'b0, j} < cnt) && (pos < 9'(SLOT_BYTES));
      bwr[l].data = b[3'(src_off + j)];
      bwaddr[l]  = AW'(open_slot) * AW'(WORDS) + AW'(pos[7:3]);
      if (is_next) bwaddr[l] = AW'(match_idx_r) * AW'(WORDS) + AW'(pos[7:3]);
    end

    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= n2kfp_pkg::ST_IDLE;
      max_age_r   <= n2kfp_pkg::MAX_AGE_RST;
      drop_r      <= '0;
      valid_r     <= '0;
      chk_vld_r   <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_age_r   <= max_age_nxt;
      drop_r      <= drop_nxt;
      valid_r     <= valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      match_r     <= match_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r        <= id_nxt;
    data_r      <= data_nxt;
    now_r       <= now_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    chk_idx_r   <= chk_idx_nxt;
    match_idx_r <= match_idx_nxt;
    mseq_r      <= mseq_nxt;
    mlen_r      <= mlen_nxt;
    mcur_r      <= mcur_nxt;
    mtime_r     <= mtime_nxt;
    free_idx_r  <= free_idx_nxt;
    emit_slot_r <= emit_slot_nxt;
    emit_len_r  <= emit_len_nxt;
    emit_k_r    <= emit_k_nxt;
    emit_n_r    <= emit_n_nxt;
    out_len_r   <= out_len_nxt;
    out_idx_r   <= out_idx_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  // output register drives the result channel; header comes from the held frame
  logic [16:0] opgn_r;
  logic [7:0]  osrc_r, odst_r;
  logic [2:0]  oprio_r;

  always_ff @(posedge clk) begin
    if (load) begin
      opgn_r  <= pgn;
      osrc_r  <= src;
      odst_r  <= dst;
      oprio_r <= prio;
    end
  end

  assign in_ch.ready          = (state_r == n2kfp_pkg::ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.pgn           = opgn_r;
  assign out_ch.source_addr   = osrc_r;
  assign out_ch.dest_addr     = odst_r;
  assign out_ch.priority_res  = oprio_r;
  assign out_ch.msg_length    = out_len_r;
  assign out_ch.chunk_index   = out_idx_r;
  assign out_ch.chunk_data    = out_data_r;
  assign out_ch.last_chunk    = out_last_r;
  assign out_ch.dropped_count = out_drop_r;

endmodule

// ===== rtl/n2kfp_checker.sv =====
// port-level checks on the result channel, bound to the top level
// depends on assert_macros.svh and n2k_fast_packet_reassembler
`timescale 1ns / 1ps
`include "assert_macros.svh"

module n2kfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  msg_length,
  input logic [4:0]  chunk_index,
  input logic [63:0] chunk_data,
  input logic        last_chunk
);

  // a stalled chunk keeps its data
  `N2KFP_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(chunk_data), "stalled chunk changed")
  // short messages fit one chunk
  `N2KFP_ASSERT(a_single, clk, rst_n, out_valid && (msg_length <= 8'd8) |-> last_chunk && (chunk_index == 5'd0), "short message not single chunk")
  // in a short message, bytes past the length read as zero
  `N2KFP_ASSERT(a_pad, clk, rst_n, out_valid && (msg_length < 8'd8) |-> ((chunk_data >> {msg_length, 3'b000}) == 64'd0), "padding not zero")
  // a non-final chunk leaves more bytes to come
  `N2KFP_ASSERT(a_more, clk, rst_n, out_valid && !last_chunk |-> (({1'b0, chunk_index, 3'b000} + 9'd8) < {1'b0, msg_length}), "early non-final chunk")
  // reset empties the output register
  `N2KFP_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind n2k_fast_packet_reassembler n2kfp_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .msg_length  (out_ch.msg_length),
  .chunk_index (out_ch.chunk_index),
  .chunk_data  (out_ch.chunk_data),
  .last_chunk  (out_ch.last_chunk)
);
